/* src/frs_pkg.sv */
package frs_pkg;

  // input request packing
  localparam int VEC_W  = 48;
  localparam int IDX_W  = 14;
  localparam int IN_W   = 112;
  localparam int REFL_W = 16;

  // long division: 62-bit dividend, 31-bit divisor, 31 quotient bits
  localparam int DIV_STEPS = 31;
  localparam int DIV_NUM_W = 62;
  localparam int DIV_DEN_W = 31;

  // square root: one result bit per stage
  localparam int SQRT_STEPS = 16;

  localparam logic [33:0] DOT_LIM  = 34'd268435456;   // 1.0 in q4.28
  localparam logic [13:0] ONE_Q12  = 14'd4096;
  localparam logic [31:0] ONE_Q30  = 32'd1073741824;
  localparam logic [15:0] ONE_Q15  = 16'd32768;

  // per-hit sideband carried alongside the long arithmetic
  typedef struct packed {
    logic        tir;
    logic        zs;
    logic        zp;
    logic [15:0] ci;
    logic [13:0] ei;
    logic [13:0] et;
  } side_t;

  typedef struct packed {
    logic        tir;
    logic [15:0] refl;
  } res_t;

endpackage

/* src/frs_div.sv */
module frs_div
  import frs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  input  side_t                side_in,
  output logic                 vld_out,
  output logic [DIV_DEN_W-1:0] quo,
  output side_t                side_out
);

  // restoring division, one quotient bit per stage; quotient assumed < 2^31
  logic [DIV_DEN_W-1:0] rem_in  [DIV_STEPS];
  logic [DIV_DEN_W-1:0] lo_in   [DIV_STEPS];
  logic [DIV_DEN_W-1:0] q_in    [DIV_STEPS];
  logic [DIV_DEN_W-1:0] den_in  [DIV_STEPS];
  logic [DIV_DEN_W:0]   trial   [DIV_STEPS];
  logic                 ge      [DIV_STEPS];
  logic [DIV_DEN_W-1:0] rem_nxt [DIV_STEPS];

  logic [DIV_DEN_W-1:0] rem_r [DIV_STEPS];
  logic [DIV_DEN_W-1:0] lo_r  [DIV_STEPS];
  logic [DIV_DEN_W-1:0] q_r   [DIV_STEPS];
  logic [DIV_DEN_W-1:0] den_r [DIV_STEPS];
  side_t                side_r [DIV_STEPS];
  logic                 vld_r [DIV_STEPS];

  always_comb begin
    rem_in[0] = num[DIV_NUM_W-1:DIV_DEN_W];
    lo_in[0]  = num[DIV_DEN_W-1:0];
    q_in[0]   = '0;
    den_in[0] = den;
    for (int i = 1; i < DIV_STEPS; i++) begin
      rem_in[i] = rem_r[i-1];
      lo_in[i]  = lo_r[i-1];
      q_in[i]   = q_r[i-1];
      den_in[i] = den_r[i-1];
    end
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial[i]   = {rem_in[i], lo_in[i][DIV_DEN_W-1]};
      ge[i]      = trial[i] >= {1'b0, den_in[i]};
      rem_nxt[i] = ge[i] ? DIV_DEN_W'(trial[i] - {1'b0, den_in[i]})
                         : trial[i][DIV_DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STEPS; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_in;
      for (int i = 1; i < DIV_STEPS; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int i = 1; i < DIV_STEPS; i++) side_r[i] <= side_r[i-1];
      for (int i = 0; i < DIV_STEPS; i++) begin
        rem_r[i]  <= rem_nxt[i];
        lo_r[i]   <= {lo_in[i][DIV_DEN_W-2:0], 1'b0};
        q_r[i]    <= {q_in[i][DIV_DEN_W-2:0], ge[i]};
        den_r[i]  <= den_in[i];
      end
    end
  end

  assign vld_out  = vld_r[DIV_STEPS-1];
  assign quo      = q_r[DIV_STEPS-1];
  assign side_out = side_r[DIV_STEPS-1];

endmodule

/* src/frs_front.sv */
module frs_front
  import frs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic [VEC_W-1:0]     incident,
  input  logic [VEC_W-1:0]     normal,
  input  logic [IDX_W-1:0]     index_ratio,
  output logic                 vld_out,
  output logic [DIV_NUM_W-1:0] num,
  output logic [DIV_DEN_W-1:0] den,
  output side_t                side_out
);

  logic signed [15:0] ix, iy, iz, nx, ny, nz;
  assign ix = incident[15:0];
  assign iy = incident[31:16];
  assign iz = incident[47:32];
  assign nx = normal[15:0];
  assign ny = normal[31:16];
  assign nz = normal[47:32];

  logic [6:0] v_r;

  // s1 products
  logic signed [31:0] px_r, py_r, pz_r;
  logic [IDX_W-1:0]   idx1_r, idx2_r;
  // s2 exact dot
  logic signed [33:0] dot_r;
  // s3 cosine and indices
  logic [33:0]        absd;
  logic [28:0]        mag;
  logic [29:0]        cisum;
  logic               from_inside;
  side_t              sd3_nxt, sd7_nxt;
  side_t              sd3_r, sd4_r, sd5_r, sd6_r, sd7_r;
  // s4..s7
  logic [31:0]        ci2_r;
  logic [27:0]        ei2_r, ei2_5_r;
  logic [27:0]        et2_4_r, et2_5_r, et2_6_r, et2_7_r;
  logic [30:0]        s2_r;
  logic [58:0]        lhs6_r, lhs7_r;

  always_comb begin
    absd        = dot_r[33] ? 34'(-dot_r) : 34'(dot_r);
    mag         = (absd > DOT_LIM) ? DOT_LIM[28:0] : absd[28:0];
    cisum       = {1'b0, mag} + 30'd4096;
    from_inside = !dot_r[33] && (dot_r != '0);

    sd3_nxt    = '0;
    sd3_nxt.ci = cisum[28:13];
    sd3_nxt.ei = from_inside ? idx2_r : ONE_Q12;
    sd3_nxt.et = from_inside ? ONE_Q12 : idx2_r;

    sd7_nxt     = sd6_r;
    sd7_nxt.tir = lhs6_r >= {1'b0, et2_6_r, 30'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= ix * nx;
      py_r   <= iy * ny;
      pz_r   <= iz * nz;
      idx1_r <= index_ratio;

      dot_r  <= 34'(px_r) + 34'(py_r) + 34'(pz_r);
      idx2_r <= idx1_r;

      sd3_r <= sd3_nxt;

      ci2_r   <= sd3_r.ci * sd3_r.ci;
      ei2_r   <= sd3_r.ei * sd3_r.ei;
      et2_4_r <= sd3_r.et * sd3_r.et;
      sd4_r   <= sd3_r;

      s2_r    <= 31'(ONE_Q30 - ci2_r);
      ei2_5_r <= ei2_r;
      et2_5_r <= et2_4_r;
      sd5_r   <= sd4_r;

      lhs6_r  <= ei2_5_r * s2_r;
      et2_6_r <= et2_5_r;
      sd6_r   <= sd5_r;

      lhs7_r  <= lhs6_r;
      et2_7_r <= et2_6_r;
      sd7_r   <= sd7_nxt;
    end
  end

  assign vld_out  = v_r[6];
  assign num      = {3'd0, lhs7_r};
  assign den      = {3'd0, et2_7_r};
  assign side_out = sd7_r;

endmodule

/* src/frs_sqrt.sv */
module frs_sqrt
  import frs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic [DIV_DEN_W-1:0] quo,
  input  side_t                side_in,
  output logic                 vld_out,
  output logic [15:0]          ct,
  output side_t                side_out
);

  // prep stage forms cos_t^2, then one root bit per stage
  logic        vp_r;
  logic [31:0] vp_val_r;
  side_t       sdp_r;

  logic [31:0] v_in  [SQRT_STEPS];
  logic [31:0] r_in  [SQRT_STEPS];
  logic [31:0] bitv  [SQRT_STEPS];
  logic [31:0] t     [SQRT_STEPS];
  logic [31:0] v_nxt [SQRT_STEPS];
  logic [31:0] r_nxt [SQRT_STEPS];

  logic [31:0] v_r   [SQRT_STEPS];
  logic [31:0] r_r   [SQRT_STEPS];
  side_t       sd_r  [SQRT_STEPS];
  logic        vld_r [SQRT_STEPS];

  always_comb begin
    v_in[0] = vp_val_r;
    r_in[0] = '0;
    for (int i = 1; i < SQRT_STEPS; i++) begin
      v_in[i] = v_r[i-1];
      r_in[i] = r_r[i-1];
    end
    for (int i = 0; i < SQRT_STEPS; i++) begin
      bitv[i] = 32'd1 << (30 - 2 * i);
      t[i]    = r_in[i] + bitv[i];
      if (v_in[i] >= t[i]) begin
        v_nxt[i] = v_in[i] - t[i];
        r_nxt[i] = (r_in[i] >> 1) + bitv[i];
      end else begin
        v_nxt[i] = v_in[i];
        r_nxt[i] = r_in[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
      for (int i = 0; i < SQRT_STEPS; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vp_r     <= vld_in;
      vld_r[0] <= vp_r;
      for (int i = 1; i < SQRT_STEPS; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vp_val_r <= ONE_Q30 - {1'b0, quo};
      sdp_r    <= side_in;
      sd_r[0]  <= sdp_r;
      for (int i = 1; i < SQRT_STEPS; i++) sd_r[i] <= sd_r[i-1];
      for (int i = 0; i < SQRT_STEPS; i++) begin
        v_r[i] <= v_nxt[i];
        r_r[i] <= r_nxt[i];
      end
    end
  end

  assign vld_out  = vld_r[SQRT_STEPS-1];
  assign ct       = r_r[SQRT_STEPS-1][15:0];
  assign side_out = sd_r[SQRT_STEPS-1];

endmodule

/* src/frs_back.sv */
module frs_back
  import frs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_in,
  input  logic [15:0] ct,
  input  side_t       side_in,
  output logic        vld_out,
  output res_t        res_out
);

  logic                 b1_v_r, b2_v_r, b3_v_r, b4_v_r;
  logic [29:0]          as_r, bs_r, ap_r, bp_r;
  side_t                sd1_r, sd2_r, sd2_nxt;
  logic [DIV_NUM_W-1:0] num_s_r, num_p_r;
  logic [DIV_DEN_W-1:0] den_s_r, den_p_r;

  logic                 vs, vp;
  logic [DIV_DEN_W-1:0] qs, qp;
  side_t                sds, sdp;

  logic [DIV_DEN_W-1:0] rs, rp;
  logic [61:0]          sqs_r, sqp_r;
  logic                 tir3_r;
  logic [62:0]          sum;
  logic [16:0]          r17;
  res_t                 res_r, res_nxt;

  frs_div u_div_s (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(b2_v_r),
    .num(num_s_r), .den(den_s_r), .side_in(sd2_r),
    .vld_out(vs), .quo(qs), .side_out(sds)
  );

  frs_div u_div_p (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(b2_v_r),
    .num(num_p_r), .den(den_p_r), .side_in(sd2_r),
    .vld_out(vp), .quo(qp), .side_out(sdp)
  );

  always_comb begin
    rs  = sds.zs ? ONE_Q30[30:0] : qs;
    rp  = sdp.zp ? ONE_Q30[30:0] : qp;
    sum = {1'b0, sqs_r} + {1'b0, sqp_r} + (63'd1 << 45);
    r17 = sum[62:46];

    sd2_nxt    = sd1_r;
    sd2_nxt.zs = (as_r == '0) && (bs_r == '0);
    sd2_nxt.zp = (ap_r == '0) && (bp_r == '0);

    res_nxt.tir  = tir3_r;
    res_nxt.refl = (tir3_r || r17 > {1'b0, ONE_Q15}) ? ONE_Q15 : r17[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      b4_v_r <= 1'b0;
    end else if (en) begin
      b1_v_r <= vld_in;
      b2_v_r <= b1_v_r;
      b3_v_r <= vs & vp;
      b4_v_r <= b3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      as_r  <= side_in.et * side_in.ci;
      bs_r  <= side_in.ei * ct;
      ap_r  <= side_in.ei * side_in.ci;
      bp_r  <= side_in.et * ct;
      sd1_r <= side_in;

      den_s_r <= {1'b0, as_r} + {1'b0, bs_r};
      den_p_r <= {1'b0, ap_r} + {1'b0, bp_r};
      num_s_r <= {2'd0, (as_r >= bs_r) ? as_r - bs_r : bs_r - as_r, 30'd0};
      num_p_r <= {2'd0, (ap_r >= bp_r) ? ap_r - bp_r : bp_r - ap_r, 30'd0};
      sd2_r   <= sd2_nxt;

      sqs_r  <= rs * rs;
      sqp_r  <= rp * rp;
      tir3_r <= sds.tir;

      res_r <= res_nxt;
    end
  end

  assign vld_out = b4_v_r;
  assign res_out = res_r;

endmodule

/* src/fresnel_reflectance_unit.sv */
// unpolarised fresnel reflectance at a dielectric boundary, one ray hit per request
// input channel in_*: tdata carries incident (three q2.14 lanes, x lowest), normal
// (same packing) and the q2.12 refractive index; accepted on in_tvalid & in_tready
// result channel out_*: tdata is the q1.15 reflectance, tuser flags total internal
// reflection (reflectance then reads 1.0)
// pipeline: 7 front stages, the 31-stage snell divider, 17 square-root stages, 4 back
// stages around the 31-stage s and p dividers (run side by side) and the output register
// throughput: one request per cycle while in_tready is high, every stage is a register
// with its own valid
// reset: synchronous active-low rst_n clears every valid bit, the unit comes out
// empty and ready
// receiver stall: the output register holds its result; one more result parks in a
// skid register, then in_tready drops and the whole pipeline freezes in place,
// losing and repeating nothing; it resumes the cycle the skid register empties
module fresnel_reflectance_unit
  import frs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // incident[47:0], normal[95:48], index_ratio[109:96]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [REFL_W-1:0] out_tdata,  // reflectance[15:0]
  output logic              out_tuser   // total_reflection
);

  // pipeline advances whenever the skid register is free
  logic adv;

  logic                 f_v;
  logic [DIV_NUM_W-1:0] f_num;
  logic [DIV_DEN_W-1:0] f_den;
  side_t                f_sd;

  logic                 d_v;
  logic [DIV_DEN_W-1:0] d_q;
  side_t                d_sd;

  logic                 s_v;
  logic [15:0]          s_ct;
  side_t                s_sd;

  logic                 p_v;
  res_t                 p_res;

  // output register and skid register
  logic out_v_r, out_v_nxt;
  res_t out_d_r, out_d_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t skid_d_r, skid_d_nxt;
  logic out_free;

  assign adv       = !skid_v_r;
  assign in_tready = adv;

  // dot product, cosine, index swap, critical-angle test
  frs_front u_front (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(in_tvalid & adv),
    .incident(in_tdata[47:0]), .normal(in_tdata[95:48]),
    .index_ratio(in_tdata[109:96]),
    .vld_out(f_v), .num(f_num), .den(f_den), .side_out(f_sd)
  );

  // eta_i^2 sin_i^2 / eta_t^2
  frs_div u_div_snell (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(f_v),
    .num(f_num), .den(f_den), .side_in(f_sd),
    .vld_out(d_v), .quo(d_q), .side_out(d_sd)
  );

  // cos_t
  frs_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(d_v),
    .quo(d_q), .side_in(d_sd),
    .vld_out(s_v), .ct(s_ct), .side_out(s_sd)
  );

  // s and p ratios, squares, mean and saturation
  frs_back u_back (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(s_v),
    .ct(s_ct), .side_in(s_sd),
    .vld_out(p_v), .res_out(p_res)
  );

  always_comb begin
    out_free   = !out_v_r || out_tready;
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    priority if (skid_v_r) begin
      if (out_free) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (p_v) begin
      if (out_free) begin
        out_v_nxt = 1'b1;
        out_d_nxt = p_res;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = p_res;
      end
    end else if (out_free) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r.refl;
  assign out_tuser  = out_d_r.tir;

`ifndef SYNTH
  // a parked result always sits behind a held one
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full while output register empty");

  // the skid register only fills when the receiver stalls a held result
  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready))
    else $error("skid register filled without a stall");

  // total internal reflection always reports full reflectance
  a_tir_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == ONE_Q15))
    else $error("total reflection without reflectance 1.0");

  // reflectance never exceeds 1.0
  a_refl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata <= ONE_Q15))
    else $error("reflectance above 1.0");
`endif

endmodule
